// ----- design/lda_pkg.sv -----
// Shared types and constants of the line rasterizer with alpha blend.
`timescale 1ns / 1ps

package lda_pkg;

  // Fixed field widths
  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int DIM_W      = 9;
  localparam int ALPHA_W    = 9;
  localparam int COUNT_W    = 10;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int ERR_W      = COORD_W + 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Blend arithmetic: new = (old*(256-a) + col*a + 128) >> 8
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam int                 BLEND_ROUND = 128;
  localparam int                 BLEND_SHIFT = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register reset values
  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 9'd256;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 9'd256;
  localparam logic [COLOR_W-1:0] BG_RESET     = 8'd0;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 9'd179;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH      = 3'd0,
    REG_FRAME_HEIGHT     = 3'd1,
    REG_BACKGROUND_RED   = 3'd2,
    REG_BACKGROUND_GREEN = 3'd3,
    REG_BACKGROUND_BLUE  = 3'd4,
    REG_BLEND_ALPHA      = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic signed [COORD_W-1:0] x_end;
    logic signed [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0]        line_red;
    logic [COLOR_W-1:0]        line_green;
    logic [COLOR_W-1:0]        line_blue;
  } req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;
    logic [COUNT_W-1:0] pixels_drawn;
    logic               read_outside;
  } rsp_t;

  // Active configuration, already clamped
  typedef struct packed {
    logic [DIM_W-1:0]   act_w;
    logic [DIM_W-1:0]   act_h;
    logic [COLOR_W-1:0] bg_red;
    logic [COLOR_W-1:0] bg_green;
    logic [COLOR_W-1:0] bg_blue;
    logic [ALPHA_W-1:0] alpha;
  } cfg_t;

  // Classified command with line setup done
  typedef struct packed {
    opcode_e                   op;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [DELTA_W-1:0]        dx;
    logic [DELTA_W-1:0]        dy;
    logic                      sx_neg;
    logic                      sy_neg;
    logic signed [ERR_W-1:0]   err0;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } cmd_t;

endpackage

// ----- design/line_draw_alpha_blend.sv -----
// Top level of the line rasterizer with on-chip RGB frame store.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. Every request gives exactly one result,
// in request order, shown on rsp_o for one cycle with done_o high; the
// receiver cannot stall it. The back end executes one command at a time: a
// clear sweeps the frame writing one pixel per cycle, a draw takes one
// Bresenham step per cycle with the store read and the blend write-back
// overlapped, a read fetches one stored pixel, and an empty clear, an
// out-of-frame read or an unused opcode finish straight from idle. The frame
// store has no reset: issue a clear before the first draw or read. Write
// configuration only while no request is pending.
module line_draw_alpha_blend
  import lda_pkg::*;
#(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  done_o,
  output rsp_t                  rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic push, full, q_vld, q_pop;

  lda_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  lda_front u_front (
    .start_i(start),
    .req_i  (req_i),
    .full_i (full),
    .busy_o (busy),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  lda_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (q_pop),
    .full_o    (full),
    .vld_o     (q_vld),
    .head_o    (head_cmd)
  );

  lda_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .q_vld_i(q_vld),
    .q_cmd_i(head_cmd),
    .q_pop_o(q_pop),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- design/lda_cfg.sv -----
// Configuration register file with clamping of frame size and alpha.
`timescale 1ns / 1ps

module lda_cfg
  import lda_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [DIM_W-1:0]   width_q, height_q;
  logic [COLOR_W-1:0] bg_red_q, bg_green_q, bg_blue_q;
  logic [ALPHA_W-1:0] alpha_q;

  // Write one register; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RESET;
      height_q   <= HEIGHT_RESET;
      bg_red_q   <= BG_RESET;
      bg_green_q <= BG_RESET;
      bg_blue_q  <= BG_RESET;
      alpha_q    <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FRAME_WIDTH:      width_q    <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT:     height_q   <= cfg_data_i[DIM_W-1:0];
        REG_BACKGROUND_RED:   bg_red_q   <= cfg_data_i[COLOR_W-1:0];
        REG_BACKGROUND_GREEN: bg_green_q <= cfg_data_i[COLOR_W-1:0];
        REG_BACKGROUND_BLUE:  bg_blue_q  <= cfg_data_i[COLOR_W-1:0];
        REG_BLEND_ALPHA:      alpha_q    <= cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to the store and alpha to one
  always_comb begin
    cfg_o.act_w    = (int'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_q;
    cfg_o.act_h    = (int'(height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_q;
    cfg_o.bg_red   = bg_red_q;
    cfg_o.bg_green = bg_green_q;
    cfg_o.bg_blue  = bg_blue_q;
    cfg_o.alpha    = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  end

endmodule

// ----- design/lda_front.sv -----
// Front end: accepts requests, decodes them and prepares line setup.
`timescale 1ns / 1ps

module lda_front
  import lda_pkg::*;
(
  input  logic start_i,
  input  req_t req_i,
  input  logic full_i,
  output logic busy_o,
  output logic push_o,
  output cmd_t cmd_o
);

  logic signed [DELTA_W-1:0] x0_ext, y0_ext, x1_ext, y1_ext;
  logic signed [DELTA_W-1:0] x_diff, y_diff;
  logic [DELTA_W-1:0]        dx, dy;
  logic                      x_up, y_up;

  // Hold requests off while the queue is full
  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  // Line deltas and step directions
  always_comb begin
    x0_ext = {req_i.x_start[COORD_W-1], req_i.x_start};
    y0_ext = {req_i.y_start[COORD_W-1], req_i.y_start};
    x1_ext = {req_i.x_end[COORD_W-1], req_i.x_end};
    y1_ext = {req_i.y_end[COORD_W-1], req_i.y_end};
    x_up   = req_i.x_end > req_i.x_start;
    y_up   = req_i.y_end > req_i.y_start;
    x_diff = x1_ext - x0_ext;
    y_diff = y1_ext - y0_ext;
    dx     = x_up ? $unsigned(x_diff) : $unsigned(-x_diff);
    dy     = y_up ? $unsigned(y_diff) : $unsigned(-y_diff);
  end

  // Build the queued command
  always_comb begin
    cmd_o.op     = opcode_e'(req_i.opcode);
    cmd_o.x0     = req_i.x_start;
    cmd_o.y0     = req_i.y_start;
    cmd_o.x1     = req_i.x_end;
    cmd_o.y1     = req_i.y_end;
    cmd_o.dx     = dx;
    cmd_o.dy     = dy;
    cmd_o.sx_neg = !(req_i.x_start < req_i.x_end);
    cmd_o.sy_neg = !(req_i.y_start < req_i.y_end);
    cmd_o.err0   = $signed(ERR_W'(dx)) - $signed(ERR_W'(dy));
    cmd_o.red    = req_i.line_red;
    cmd_o.green  = req_i.line_green;
    cmd_o.blue   = req_i.line_blue;
  end

endmodule

// ----- design/lda_queue.sv -----
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps

module lda_queue
  import lda_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic vld_o,
  output cmd_t head_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign full_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign vld_o  = (count_q != '0);
  assign head_o = entry_q[rd_ptr_q];
  assign do_pop = pop_i && vld_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

endmodule

// ----- design/lda_back.sv -----
// Back end: executes clear, draw and read against the frame store.
`timescale 1ns / 1ps

module lda_back
  import lda_pkg::*;
#(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_vld_i,
  input  cmd_t q_cmd_i,
  output logic q_pop_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int XI_W   = $clog2(MAX_WIDTH);
  localparam int YI_W   = $clog2(MAX_HEIGHT);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CB     = CHANNEL_BITS;
  localparam int WORD_W = 3 * CB;
  localparam int MW     = CB + 10;
  localparam int EW     = ERR_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_READ,
    ST_DRAIN
  } state_e;

  function automatic logic in_frame(logic signed [COORD_W-1:0] x,
                                    logic signed [COORD_W-1:0] y,
                                    logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    return !x[COORD_W-1] && !y[COORD_W-1] &&
           ($unsigned(x) < COORD_W'(w)) && ($unsigned(y) < COORD_W'(h));
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(logic [XI_W-1:0] xi,
                                                 logic [YI_W-1:0] yi);
    return ADDR_W'(yi) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xi);
  endfunction

  function automatic logic [CB-1:0] to_ch(logic [COLOR_W-1:0] v);
    logic [15:0] t;
    t = 16'(v);
    return t[CB-1:0];
  endfunction

  function automatic logic [COLOR_W-1:0] from_ch(logic [CB-1:0] v);
    logic [15:0] t;
    t = 16'(v);
    return t[COLOR_W-1:0];
  endfunction

  function automatic logic [CB-1:0] mix(logic [CB-1:0] old, logic [CB-1:0] col,
                                        logic [ALPHA_W-1:0] a);
    logic [MW-1:0] acc;
    acc = MW'(old) * MW'(ALPHA_ONE - a) + MW'(col) * MW'(a) + MW'(BLEND_ROUND);
    return acc[CB+BLEND_SHIFT-1:BLEND_SHIFT];
  endfunction

  // Frame store
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  state_e                    state_q;
  logic signed [COORD_W-1:0] x_q, y_q, x1_q, y1_q;
  logic [DELTA_W-1:0]        dx_q, dy_q;
  logic                      sxn_q, syn_q;
  logic signed [ERR_W-1:0]   err_q;
  logic [CB-1:0]             red_q, green_q, blue_q;
  logic [COUNT_W-1:0]        cnt_q, cnt_d;
  logic [XI_W-1:0]           cx_q;
  logic [YI_W-1:0]           cy_q;
  logic                      wb_vld_q;
  logic [ADDR_W-1:0]         wb_addr_q;
  logic                      done_q;
  rsp_t                      rsp_q;

  logic                      pop, head_in, cur_in, at_end, clr_we, cx_last, cy_last;
  logic [ADDR_W-1:0]         cur_addr, head_addr, clr_addr;
  logic signed [EW-1:0]      e2, dx_s, dy_s, err_w;
  logic                      step_x, step_y;
  logic signed [COORD_W-1:0] x_d, y_d;
  logic [WORD_W-1:0]         blend_word, bg_word;

  assign pop     = (state_q == ST_IDLE) && q_vld_i;
  assign q_pop_o = pop;
  assign done_o  = done_q;
  assign rsp_o   = rsp_q;

  // Current line pixel and Bresenham step
  always_comb begin
    cur_in   = in_frame(x_q, y_q, cfg_i.act_w, cfg_i.act_h);
    cur_addr = pix_addr(x_q[XI_W-1:0], y_q[YI_W-1:0]);
    at_end   = (x_q == x1_q) && (y_q == y1_q);
    e2       = {err_q, 1'b0};
    dx_s     = $signed(EW'(dx_q));
    dy_s     = $signed(EW'(dy_q));
    step_x   = e2 > -dy_s;
    step_y   = e2 < dx_s;
    err_w    = $signed({err_q[ERR_W-1], err_q}) - (step_x ? dy_s : '0)
               + (step_y ? dx_s : '0);
    x_d      = step_x ? (sxn_q ? x_q - 1'b1 : x_q + 1'b1) : x_q;
    y_d      = step_y ? (syn_q ? y_q - 1'b1 : y_q + 1'b1) : y_q;
    cnt_d    = (cur_in && cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
  end

  // Clear sweep position and the head read address
  always_comb begin
    clr_addr  = pix_addr(cx_q, cy_q);
    cx_last   = (16'(cx_q) + 16'd1) == 16'(cfg_i.act_w);
    cy_last   = (16'(cy_q) + 16'd1) == 16'(cfg_i.act_h);
    head_in   = in_frame(q_cmd_i.x0, q_cmd_i.y0, cfg_i.act_w, cfg_i.act_h);
    head_addr = pix_addr(q_cmd_i.x0[XI_W-1:0], q_cmd_i.y0[YI_W-1:0]);
  end

  // Store port selection: clear and blend write-back never overlap
  always_comb begin
    blend_word = {mix(rd_data_q[3*CB-1:2*CB], red_q, cfg_i.alpha),
                  mix(rd_data_q[2*CB-1:CB], green_q, cfg_i.alpha),
                  mix(rd_data_q[CB-1:0], blue_q, cfg_i.alpha)};
    bg_word    = {to_ch(cfg_i.bg_red), to_ch(cfg_i.bg_green), to_ch(cfg_i.bg_blue)};
    clr_we     = (state_q == ST_CLEAR);
    mem_we     = clr_we || wb_vld_q;
    mem_waddr  = wb_vld_q ? wb_addr_q : clr_addr;
    mem_wdata  = wb_vld_q ? blend_word : bg_word;
    mem_re     = ((state_q == ST_DRAW) && cur_in) ||
                 (pop && (q_cmd_i.op == OP_READ) && head_in);
    mem_raddr  = (state_q == ST_DRAW) ? cur_addr : head_addr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // Sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      x_q       <= '0;
      y_q       <= '0;
      x1_q      <= '0;
      y1_q      <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      sxn_q     <= 1'b0;
      syn_q     <= 1'b0;
      err_q     <= '0;
      red_q     <= '0;
      green_q   <= '0;
      blue_q    <= '0;
      cnt_q     <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      wb_vld_q  <= 1'b0;
      wb_addr_q <= '0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
    end else begin
      done_q   <= 1'b0;
      wb_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            rsp_q <= '0;
            case (q_cmd_i.op)
              OP_CLEAR: begin
                cx_q <= '0;
                cy_q <= '0;
                if (cfg_i.act_w == '0 || cfg_i.act_h == '0) begin
                  done_q <= 1'b1;
                end else begin
                  state_q <= ST_CLEAR;
                end
              end
              OP_DRAW: begin
                x_q     <= q_cmd_i.x0;
                y_q     <= q_cmd_i.y0;
                x1_q    <= q_cmd_i.x1;
                y1_q    <= q_cmd_i.y1;
                dx_q    <= q_cmd_i.dx;
                dy_q    <= q_cmd_i.dy;
                sxn_q   <= q_cmd_i.sx_neg;
                syn_q   <= q_cmd_i.sy_neg;
                err_q   <= q_cmd_i.err0;
                red_q   <= to_ch(q_cmd_i.red);
                green_q <= to_ch(q_cmd_i.green);
                blue_q  <= to_ch(q_cmd_i.blue);
                cnt_q   <= '0;
                state_q <= ST_DRAW;
              end
              OP_READ: begin
                if (head_in) begin
                  state_q <= ST_READ;
                end else begin
                  rsp_q.read_outside <= 1'b1;
                  done_q             <= 1'b1;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if (cx_last) begin
            cx_q <= '0;
            cy_q <= cy_q + 1'b1;
            if (cy_last) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end else begin
            cx_q <= cx_q + 1'b1;
          end
        end
        ST_DRAW: begin
          // issue read for this pixel, blend it next cycle
          wb_vld_q  <= cur_in;
          wb_addr_q <= cur_addr;
          cnt_q     <= cnt_d;
          if (at_end) begin
            state_q <= ST_DRAIN;
          end else begin
            x_q   <= x_d;
            y_q   <= y_d;
            err_q <= err_w[ERR_W-1:0];
          end
        end
        ST_DRAIN: begin
          rsp_q.pixels_drawn <= cnt_q;
          done_q             <= 1'b1;
          state_q            <= ST_IDLE;
        end
        ST_READ: begin
          rsp_q.pixel_red   <= from_ch(rd_data_q[3*CB-1:2*CB]);
          rsp_q.pixel_green <= from_ch(rd_data_q[2*CB-1:CB]);
          rsp_q.pixel_blue  <= from_ch(rd_data_q[CB-1:0]);
          done_q            <= 1'b1;
          state_q           <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_wr_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_we && wb_vld_q))
    else $error("clear write collides with blend write-back");

  a_wb_after_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_vld_q |-> $past(state_q == ST_DRAW))
    else $error("blend write-back without a draw step");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wb_vld_q)
    else $error("next command could start before write-back completes");

  a_read_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> $past(mem_re))
    else $error("pixel read result without a store read");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the line rasterizer with alpha blend.
`timescale 1ns / 1ps

module testbench;
  import lda_pkg::*;

  localparam int PITCH          = 256;
  localparam int FRAME_MAX      = 256;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int MAX_GAP        = 16;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int TAIL_CYCLES    = 32;

  // Register indexes past the last real register; writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  req_t                  req_i;
  logic                  done_o;
  rsp_t                  rsp_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow frame store and registers of the predictor
  logic [3*COLOR_W-1:0] frame_pixels [PITCH*FRAME_MAX];
  logic [DIM_W-1:0]     shadow_width;
  logic [DIM_W-1:0]     shadow_height;
  logic [COLOR_W-1:0]   shadow_red;
  logic [COLOR_W-1:0]   shadow_green;
  logic [COLOR_W-1:0]   shadow_blue;
  logic [ALPHA_W-1:0]   shadow_alpha;

  rsp_t        frame_replies_q [$];
  int          error_count;
  int          reply_count;
  int unsigned stall_cycles;
  bit          gaps_on;

  line_draw_alpha_blend DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Blend one channel toward the line color
  function automatic logic [COLOR_W-1:0] blend(logic [COLOR_W-1:0] old_c,
                                               logic [COLOR_W-1:0] col, int a);
    int sum;
    sum = int'(old_c) * (256 - a) + int'(col) * a + 128;
    return COLOR_W'(sum >> 8);
  endfunction

  // Apply one request to the shadow frame and return the reply it gives
  function automatic rsp_t render_command(req_t r);
    rsp_t                 res;
    int                   w, h, a, x, y, x1, y1, dx, dy, sx, sy, err, e2, addr;
    bit                   walking;
    logic [3*COLOR_W-1:0] px;
    res = '0;
    w = (shadow_width > FRAME_MAX) ? FRAME_MAX : int'(shadow_width);
    h = (shadow_height > FRAME_MAX) ? FRAME_MAX : int'(shadow_height);
    a = (shadow_alpha > 256) ? 256 : int'(shadow_alpha);
    case (opcode_e'(r.opcode))
      OP_CLEAR: begin
        for (y = 0; y < h; y++)
          for (x = 0; x < w; x++)
            frame_pixels[y*PITCH + x] = {shadow_red, shadow_green, shadow_blue};
      end
      OP_DRAW: begin
        x  = int'($signed(r.x_start));
        y  = int'($signed(r.y_start));
        x1 = int'($signed(r.x_end));
        y1 = int'($signed(r.y_end));
        dx = (x1 > x) ? x1 - x : x - x1;
        dy = (y1 > y) ? y1 - y : y - y1;
        sx = (x < x1) ? 1 : -1;
        sy = (y < y1) ? 1 : -1;
        err = dx - dy;
        walking = 1'b1;
        while (walking) begin
          if (x >= 0 && y >= 0 && x < w && y < h) begin
            addr = y*PITCH + x;
            px = frame_pixels[addr];
            frame_pixels[addr] = {blend(px[23:16], r.line_red, a),
                                  blend(px[15:8], r.line_green, a),
                                  blend(px[7:0], r.line_blue, a)};
            if (res.pixels_drawn != COUNT_MAX) res.pixels_drawn = res.pixels_drawn + 1'b1;
          end
          if (x == x1 && y == y1) begin
            walking = 1'b0;
          end else begin
            e2 = 2 * err;
            if (e2 > -dy) begin
              err -= dy;
              x += sx;
            end
            if (e2 < dx) begin
              err += dx;
              y += sy;
            end
          end
        end
      end
      OP_READ: begin
        x = int'($signed(r.x_start));
        y = int'($signed(r.y_start));
        if (x >= 0 && y >= 0 && x < w && y < h) begin
          px = frame_pixels[y*PITCH + x];
          res.pixel_red   = px[23:16];
          res.pixel_green = px[15:8];
          res.pixel_blue  = px[7:0];
        end else begin
          res.read_outside = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t random_req();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(req_t)-1:0];
  endfunction

  // Request with the given opcode and endpoints; color and the rest random
  function automatic req_t command(opcode_e op, int xs, int ys, int xe, int ye);
    req_t r;
    r = random_req();
    r.opcode  = op;
    r.x_start = COORD_W'(xs);
    r.y_start = COORD_W'(ys);
    r.x_end   = COORD_W'(xe);
    r.y_end   = COORD_W'(ye);
    return r;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // Frame extent: mostly small, sometimes large, empty or past the maximum
  function automatic int pick_extent(bit roomy);
    int kind;
    if (!roomy) return $urandom_range(1, 16);
    kind = $urandom_range(0, 19);
    if (kind == 0) return 0;
    if (kind <= 2) return $urandom_range(257, 511);
    if (kind <= 5) return $urandom_range(25, 256);
    return $urandom_range(1, 24);
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want_v);
    $display("reply %0d: %s got %0h want %0h", reply_count, what, got, want_v);
    error_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_FRAME_WIDTH:      shadow_width  = val;
      REG_FRAME_HEIGHT:     shadow_height = val;
      REG_BACKGROUND_RED:   shadow_red    = val[COLOR_W-1:0];
      REG_BACKGROUND_GREEN: shadow_green  = val[COLOR_W-1:0];
      REG_BACKGROUND_BLUE:  shadow_blue   = val[COLOR_W-1:0];
      REG_BLEND_ALPHA:      shadow_alpha  = val;
      default: ;
    endcase
  endtask

  // Program every register, plus one write to an unused index
  task automatic set_frame(int w, int h, int red, int green, int blue, int alpha);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_BACKGROUND_RED, CFG_DATA_W'(red));
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
              CFG_DATA_W'($urandom_range(0, 511)));
    write_reg(REG_BACKGROUND_GREEN, CFG_DATA_W'(green));
    write_reg(REG_BACKGROUND_BLUE, CFG_DATA_W'(blue));
    write_reg(REG_BLEND_ALPHA, CFG_DATA_W'(alpha));
    cfg_we_i <= 1'b0;
  endtask

  // Hold off, then present one request until the block takes it
  task automatic send_request(req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    frame_replies_q.insert(frame_replies_q.size(), render_command(r));
  endtask

  // Drop start and wait until every pending reply has come back
  task automatic drain_replies();
    start <= 1'b0;
    do @(negedge clk_i); while (frame_replies_q.size() != 0);
    @(posedge clk_i);
  endtask

  // Clear, draw and read with the register values straight out of reset
  task automatic test_reset_values();
    send_request(command(OP_CLEAR, 0, 0, 0, 0));
    send_request(command(OP_DRAW, 3, 4, 10, 4));
    send_request(command(OP_READ, 5, 4, 0, 0));
    send_request(command(OP_READ, 256, 0, 0, 0));
  endtask

  // Oversized extents, full-range endpoints, alpha at both ends
  task automatic test_frame_edges();
    drain_replies();
    set_frame(511, 1, 9'h1FF, 9'h000, 9'h1A5, 256);
    send_request(command(OP_CLEAR, 0, 0, 0, 0));
    send_request(command(OP_DRAW, -32768, 0, 32767, 0));
    send_request(command(OP_READ, 255, 0, 0, 0));
    send_request(command(OP_READ, -32768, -32768, 0, 0));
    drain_replies();
    set_frame(1, 400, 12, 34, 56, 0);
    send_request(command(OP_CLEAR, 0, 0, 0, 0));
    send_request(command(OP_DRAW, 0, -32768, 0, 32767));
    send_request(command(OP_READ, 0, 255, 0, 0));
    send_request(command(OP_READ, 32767, 32767, 0, 0));
  endtask

  // Zero width: nothing is touched and every read falls outside
  task automatic test_empty_frame();
    drain_replies();
    set_frame(0, 8, 77, 88, 99, 300);
    send_request(command(OP_CLEAR, 0, 0, 0, 0));
    send_request(command(OP_DRAW, 0, 0, 7, 7));
    send_request(command(OP_READ, 0, 0, 0, 0));
    send_request(command(OP_NOP, 1, 2, 3, 4));
  endtask

  // Lines in five directions from the center and one back into it, some crossing the border
  task automatic test_line_octants();
    drain_replies();
    set_frame(16, 12, $urandom_range(0, 511), $urandom_range(0, 511),
              $urandom_range(0, 511), 179);
    send_request(command(OP_CLEAR, 0, 0, 0, 0));
    send_request(command(OP_DRAW, 8, 6, 15, 9));
    send_request(command(OP_DRAW, 8, 6, 10, -3));
    send_request(command(OP_DRAW, 8, 6, -4, 8));
    send_request(command(OP_DRAW, 8, 6, 6, 20));
    send_request(command(OP_DRAW, 8, 6, 20, 20));
    send_request(command(OP_DRAW, 15, 9, 8, 6));
    send_request(command(OP_READ, 12, 7, 0, 0));
    send_request(command(OP_READ, 9, 4, 0, 0));
  endtask

  // Random frames, each cleared first, then a random mix of requests
  task automatic test_random_scenes();
    int   sent, phase, n, pause_at, kind, sub, w, h, ew, eh;
    int   x0, y0, x1, y1, bx, by, alpha, pick;
    req_t r;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_replies();
      w  = pick_extent(1'b1);
      ew = (w > FRAME_MAX) ? FRAME_MAX : w;
      h  = pick_extent(ew <= 24);
      eh = (h > FRAME_MAX) ? FRAME_MAX : h;
      pick = $urandom_range(0, 9);
      case (pick)
        0:       alpha = 0;
        1:       alpha = 256;
        2:       alpha = $urandom_range(257, 511);
        3:       alpha = 179;
        default: alpha = $urandom_range(0, 256);
      endcase
      set_frame(w, h, $urandom_range(0, 511), $urandom_range(0, 511),
                $urandom_range(0, 511), alpha);
      gaps_on = ($urandom_range(0, 9) >= 3);
      r = random_req();
      r.opcode = OP_CLEAR;
      send_request(r);
      sent++;
      n = $urandom_range(20, 60);
      pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        kind = $urandom_range(0, 99);
        r = random_req();
        if (kind < 58) begin
          sub = $urandom_range(0, 9);
          if (sub < 2) begin
            // short line anywhere in the coordinate range
            bx = int'($urandom_range(0, 65535)) - 32768;
            by = int'($urandom_range(0, 65535)) - 32768;
            x0 = clamp_coord(bx + int'($urandom_range(0, 40)) - 20);
            y0 = clamp_coord(by + int'($urandom_range(0, 40)) - 20);
            x1 = clamp_coord(bx + int'($urandom_range(0, 40)) - 20);
            y1 = clamp_coord(by + int'($urandom_range(0, 40)) - 20);
          end else begin
            x0 = int'($urandom_range(0, ew + 15)) - 8;
            y0 = int'($urandom_range(0, eh + 15)) - 8;
            x1 = int'($urandom_range(0, ew + 15)) - 8;
            y1 = int'($urandom_range(0, eh + 15)) - 8;
            if (sub == 2) begin
              x1 = x0;
              y1 = y0;
            end else if (sub == 3) begin
              if ($urandom_range(0, 1)) y1 = y0;
              else x1 = x0;
            end
          end
          r = command(OP_DRAW, x0, y0, x1, y1);
        end else if (kind < 88) begin
          r.opcode = OP_READ;
          if (ew > 0 && eh > 0 && $urandom_range(0, 4) != 0) begin
            r.x_start = COORD_W'($urandom_range(0, ew - 1));
            r.y_start = COORD_W'($urandom_range(0, eh - 1));
          end
        end else if (kind < 94) begin
          r.opcode = OP_CLEAR;
        end else begin
          r.opcode = OP_NOP;
        end
        // hold the sender until the block has answered everything
        if (i == pause_at) drain_replies();
        send_request(r);
        if (r.opcode != OP_NOP) sent++;
      end
      phase++;
    end
  endtask

  // Compare each reply with the oldest prediction
  always @(posedge clk_i) begin : check_reply
    rsp_t want;
    if (rst_ni && done_o) begin
      reply_count++;
      if (frame_replies_q.size() == 0) begin
        flag_mismatch("reply with none pending", 16'd1, 16'd0);
      end else begin
        want = frame_replies_q.pop_front();
        if (rsp_o.pixel_red !== want.pixel_red)
          flag_mismatch("pixel_red", 16'(rsp_o.pixel_red), 16'(want.pixel_red));
        if (rsp_o.pixel_green !== want.pixel_green)
          flag_mismatch("pixel_green", 16'(rsp_o.pixel_green), 16'(want.pixel_green));
        if (rsp_o.pixel_blue !== want.pixel_blue)
          flag_mismatch("pixel_blue", 16'(rsp_o.pixel_blue), 16'(want.pixel_blue));
        if (rsp_o.pixels_drawn !== want.pixels_drawn)
          flag_mismatch("pixels_drawn", 16'(rsp_o.pixels_drawn), 16'(want.pixels_drawn));
        if (rsp_o.read_outside !== want.read_outside)
          flag_mismatch("read_outside", 16'(rsp_o.read_outside), 16'(want.read_outside));
      end
    end
  end

  // Abort when nothing is taken or returned for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    shadow_width  = WIDTH_RESET;
    shadow_height = HEIGHT_RESET;
    shadow_red    = BG_RESET;
    shadow_green  = BG_RESET;
    shadow_blue   = BG_RESET;
    shadow_alpha  = ALPHA_RESET;
    error_count   = 0;
    reply_count   = 0;
    gaps_on       = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_frame_edges();
    test_empty_frame();
    test_line_octants();
    test_random_scenes();
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lda_pkg.sv
design/lda_cfg.sv
design/lda_front.sv
design/lda_queue.sv
design/lda_back.sv
design/line_draw_alpha_blend.sv
test/testbench.sv
